[rtl/transaction_table_retry_timer_macros.svh]
// Assertion macros used by the transaction table back end
`ifndef TRANSACTION_TABLE_RETRY_TIMER_MACROS_SVH
`define TRANSACTION_TABLE_RETRY_TIMER_MACROS_SVH

// condition that must hold on every clock edge outside reset
`define TTRT_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent in any cycle implies consequent in the same cycle
`define TTRT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/ttrt_pkg.sv]
// Types and constants of the transaction table with retry timer
package ttrt_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int MAX_RES   = 8;

	localparam logic [3:0] ACT_ALLOC    = 4'd0;
	localparam logic [3:0] ACT_FIND_B   = 4'd1;
	localparam logic [3:0] ACT_FIND_H   = 4'd2;
	localparam logic [3:0] ACT_MARK     = 4'd3;
	localparam logic [3:0] ACT_AWAIT    = 4'd4;
	localparam logic [3:0] ACT_COMPLETE = 4'd5;
	localparam logic [3:0] ACT_FAIL     = 4'd6;
	localparam logic [3:0] ACT_FREE     = 4'd7;
	localparam logic [3:0] ACT_TICK     = 4'd8;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_RESEND = 2'd1;
	localparam logic [1:0] EV_FAILED = 2'd2;

	localparam logic [1:0] PH_ACK    = 2'd0;
	localparam logic [1:0] PH_STATUS = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;
	localparam logic [1:0] PH_FAILED = 2'd3;

	localparam logic [1:0] REG_HOST_TO = 2'd0;
	localparam logic [1:0] REG_ACK_TO  = 2'd1;
	localparam logic [1:0] REG_RETRIES = 2'd2;

	typedef enum logic [3:0] {
		OP_ALLOC,
		OP_FIND_B,
		OP_FIND_H,
		OP_MARK,
		OP_AWAIT,
		OP_COMPLETE,
		OP_FAIL,
		OP_FREE,
		OP_TICK,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        slot_ok;
		logic [2:0]  slot;
		logic [15:0] host_sn;
		logic [15:0] board_sn;
		logic [31:0] now;
	} item_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  slot;
		logic [15:0] board_sn;
		logic [15:0] host_sn;
		logic [1:0]  ev;
		logic [1:0]  retries;
	} res_t;

	typedef struct packed {
		logic [15:0] board_sn;
		logic [15:0] host_sn;
		logic [31:0] attempt;
		logic [31:0] first;
		logic [1:0]  retries;
		logic [1:0]  phase;
	} entry_t;

	typedef struct packed {
		logic [15:0] host_to;
		logic [15:0] ack_to;
		logic [1:0]  max_retries;
	} cfg_t;

endpackage

[rtl/ttrt_ram.sv]
// Generic single-write, registered-read RAM
module ttrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/ttrt_front.sv]
// Front end: accepts transactions, decodes the action, queues them for the back end
module ttrt_front import ttrt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  action,
	input  logic [2:0]  slot,
	input  logic [15:0] host_sn,
	input  logic [15:0] board_sn,
	input  logic [31:0] now_ms,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t       fifo_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	item_t       dec;

	always_comb begin
		dec.slot_ok  = (32'(slot) < SLOTS);
		dec.slot     = slot;
		dec.host_sn  = host_sn;
		dec.board_sn = board_sn;
		dec.now      = now_ms;
		unique case (action)
			ACT_ALLOC:    dec.op = OP_ALLOC;
			ACT_FIND_B:   dec.op = OP_FIND_B;
			ACT_FIND_H:   dec.op = OP_FIND_H;
			ACT_MARK:     dec.op = OP_MARK;
			ACT_AWAIT:    dec.op = OP_AWAIT;
			ACT_COMPLETE: dec.op = OP_COMPLETE;
			ACT_FAIL:     dec.op = OP_FAIL;
			ACT_FREE:     dec.op = OP_FREE;
			ACT_TICK:     dec.op = OP_TICK;
			default:      dec.op = OP_NONE;
		endcase
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

endmodule

[rtl/ttrt_back.sv]
// Back end: executes queued transactions against the slot table and emits results
`include "transaction_table_retry_timer_macros.svh"

module ttrt_back import ttrt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int PW = $clog2(SLOTS + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [2:0]  slot_out,
	output logic [15:0] board_seq_out,
	output logic [15:0] host_seq_out,
	output logic [1:0]  event_res,
	output logic [1:0]  retry_used,
	output logic [3:0]  pending_total,
	output logic [31:0] timeout_total,
	output logic [31:0] retry_total,
	output logic        last
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_EXEC = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	item_t             cur_q;
	logic [AW:0]       idx_q, idx_d;
	logic [SLOTS-1:0]  used_q, used_d, sent_q, sent_d;
	logic [15:0]       next_seq_q, next_seq_d;
	logic [31:0]       tmo_q, tmo_d, rty_q, rty_d;
	logic [PW-1:0]     pend_q, pend_d;
	logic [3:0]        ev_cnt_q, ev_cnt_d;
	logic [2:0]        emit_q, emit_d;
	res_t              res_buf_q [MAX_RES];
	logic              buf_we;
	logic [2:0]        buf_idx;
	res_t              buf_data;

	logic              ram_we;
	entry_t            ram_wdata, rd, wr;
	logic [AW-1:0]     ram_raddr, i;
	logic [3:0]        n_res;
	logic              last_now, out_load, was_used, old_p, new_p, slot_op;
	logic [1:0]        ev;
	logic [31:0]       age_first, age_att;

	logic              out_valid_q;
	res_t              out_res_q;
	logic [3:0]        out_pend_q;
	logic [31:0]       out_tmo_q, out_rty_q;
	logic              out_last_q;

	ttrt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (i),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	assign i         = idx_q[AW-1:0];
	assign ram_raddr = idx_q[AW-1:0];
	assign age_first = cur_q.now - rd.first;
	assign age_att   = cur_q.now - rd.attempt;
	assign n_res     = (ev_cnt_q == 4'd0) ? 4'd1 : ev_cnt_q;
	assign last_now  = ({1'b0, emit_q} + 4'd1 == n_res);
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign slot_op   = (cur_q.op == OP_MARK) || (cur_q.op == OP_AWAIT) ||
		(cur_q.op == OP_COMPLETE) || (cur_q.op == OP_FAIL) || (cur_q.op == OP_FREE);

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		used_d     = used_q;
		sent_d     = sent_q;
		next_seq_d = next_seq_q;
		tmo_d      = tmo_q;
		rty_d      = rty_q;
		pend_d     = pend_q;
		ev_cnt_d   = ev_cnt_q;
		emit_d     = emit_q;
		buf_we     = 1'b0;
		buf_idx    = 3'd0;
		buf_data   = '0;
		ram_we     = 1'b0;
		wr         = rd;
		ram_wdata  = rd;
		q_pop      = 1'b0;
		ev         = EV_NONE;
		was_used   = used_q[i];
		old_p      = 1'b0;
		new_p      = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop    = 1'b1;
					buf_we   = 1'b1;
					ev_cnt_d = 4'd0;
					emit_d   = 3'd0;
					idx_d    = '0;
					if (q_item.op == OP_NONE) begin
						state_d = ST_EMIT;
					end else if (q_item.op == OP_MARK || q_item.op == OP_AWAIT ||
						q_item.op == OP_COMPLETE || q_item.op == OP_FAIL ||
						q_item.op == OP_FREE) begin
						idx_d   = (AW + 1)'(q_item.slot);
						state_d = q_item.slot_ok ? ST_READ : ST_EMIT;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_READ;
				if (idx_q == (AW + 1)'(SLOTS - 1)) begin
					state_d = ST_EMIT;
				end
				idx_d = idx_q + 1'b1;
				if (cur_q.op == OP_ALLOC) begin
					if (!used_q[i]) begin
						wr.board_sn = next_seq_q;
						wr.host_sn  = cur_q.host_sn;
						wr.attempt  = '0;
						wr.first    = '0;
						wr.retries  = 2'd0;
						wr.phase    = PH_ACK;
						ram_we      = 1'b1;
						ram_wdata   = wr;
						used_d[i]   = 1'b1;
						sent_d[i]   = 1'b0;
						next_seq_d  = next_seq_q + 16'd1;
						pend_d      = pend_q + 1'b1;
						buf_we      = 1'b1;
						buf_data    = '{1'b1, 3'(i), next_seq_q, cur_q.host_sn,
							EV_NONE, 2'd0};
						state_d     = ST_EMIT;
					end
				end else if (cur_q.op == OP_FIND_B || cur_q.op == OP_FIND_H) begin
					if (used_q[i] && ((cur_q.op == OP_FIND_B) ?
						(rd.board_sn == cur_q.board_sn) :
						(rd.host_sn == cur_q.host_sn))) begin
						buf_we   = 1'b1;
						buf_data = '{1'b1, 3'(i), rd.board_sn, rd.host_sn,
							EV_NONE, rd.retries};
						state_d  = ST_EMIT;
					end
				end else if (slot_op) begin
					old_p = was_used && (rd.phase <= PH_STATUS);
					priority case (cur_q.op)
						OP_MARK: begin
							if (!sent_q[i]) begin
								wr.first = cur_q.now;
							end
							wr.attempt = cur_q.now;
							sent_d[i]  = 1'b1;
						end
						OP_AWAIT:    wr.phase = PH_STATUS;
						OP_COMPLETE: wr.phase = PH_DONE;
						OP_FAIL:     wr.phase = PH_FAILED;
						default: begin
							used_d[i] = 1'b0;
							wr.first  = '0;
						end
					endcase
					new_p = used_d[i] && (wr.phase <= PH_STATUS);
					if (old_p && !new_p) begin
						pend_d = pend_q - 1'b1;
					end else if (!old_p && new_p) begin
						pend_d = pend_q + 1'b1;
					end
					ram_we    = 1'b1;
					ram_wdata = wr;
					if (was_used) begin
						buf_we   = 1'b1;
						buf_data = '{1'b1, 3'(i), rd.board_sn, rd.host_sn,
							EV_NONE, rd.retries};
					end
					state_d = ST_EMIT;
				end else begin
					if (used_q[i] && (rd.phase <= PH_STATUS) && sent_q[i]) begin
						if (age_first >= {16'd0, cfg.host_to}) begin
							tmo_d    = tmo_q + 32'd1;
							wr.phase = PH_FAILED;
							ev       = EV_FAILED;
							pend_d   = pend_q - 1'b1;
						end else if (rd.phase == PH_ACK &&
							age_att >= {16'd0, cfg.ack_to}) begin
							tmo_d = tmo_q + 32'd1;
							if (rd.retries < cfg.max_retries) begin
								wr.retries = rd.retries + 2'd1;
								wr.attempt = cur_q.now;
								rty_d      = rty_q + 32'd1;
								ev         = EV_RESEND;
							end else begin
								wr.phase = PH_FAILED;
								ev       = EV_FAILED;
								pend_d   = pend_q - 1'b1;
							end
						end
					end
					ram_we    = 1'b1;
					ram_wdata = wr;
					if (ev != EV_NONE && ev_cnt_q < 4'(MAX_RES)) begin
						buf_we   = 1'b1;
						buf_idx  = ev_cnt_q[2:0];
						buf_data = '{1'b1, 3'(i), wr.board_sn, wr.host_sn, ev,
							wr.retries};
						ev_cnt_d = ev_cnt_q + 4'd1;
					end
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					if (last_now) begin
						emit_d  = 3'd0;
						state_d = ST_IDLE;
					end else begin
						emit_d = emit_q + 3'd1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			used_q      <= '0;
			sent_q      <= '0;
			next_seq_q  <= 16'd1;
			tmo_q       <= '0;
			rty_q       <= '0;
			pend_q      <= '0;
			ev_cnt_q    <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			used_q     <= used_d;
			sent_q     <= sent_d;
			next_seq_q <= next_seq_d;
			tmo_q      <= tmo_d;
			rty_q      <= rty_d;
			pend_q     <= pend_d;
			ev_cnt_q   <= ev_cnt_d;
			emit_q     <= emit_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (buf_we) begin
			res_buf_q[buf_idx] <= buf_data;
		end
		if (out_load) begin
			out_res_q  <= res_buf_q[emit_q];
			out_pend_q <= (32'(pend_q) > 32'd15) ? 4'd15 : 4'(pend_q);
			out_tmo_q  <= tmo_q;
			out_rty_q  <= rty_q;
			out_last_q <= last_now;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = out_res_q.ok;
	assign slot_out      = out_res_q.slot;
	assign board_seq_out = out_res_q.board_sn;
	assign host_seq_out  = out_res_q.host_sn;
	assign event_res     = out_res_q.ev;
	assign retry_used    = out_res_q.retries;
	assign pending_total = out_pend_q;
	assign timeout_total = out_tmo_q;
	assign retry_total   = out_rty_q;
	assign last          = out_last_q;

	`TTRT_ASSERT_ALWAYS(a_pend_le_used, 32'(pend_q) <= $countones(used_q), "pending above used")
	`TTRT_ASSERT_IMPLIES(a_emit_in_range, state_q == ST_EMIT, {1'b0, emit_q} < n_res, "emit index overrun")
	`TTRT_ASSERT_IMPLIES(a_pop_idle, q_pop, state_q == ST_IDLE, "pop outside idle")

endmodule

[rtl/transaction_table_retry_timer.sv]
// Top level of the outstanding transaction table with acknowledge timeout and retry
//
// Input channel (in_valid/in_stall) takes one transaction per accept: an action with
// slot, host_sn, board_sn and now_ms. Output channel (out_valid/out_stall) returns
// one or more results per transaction, the final one flagged by last; a tick gives one
// result per slot event, up to eight, or one result with ok low when there is none.
// Registers sit on the APB port at 0x0 (host timeout), 0x4 (ack timeout) and 0x8
// (retry limit), to be written only while idle; the block does not enforce this.
// A two-entry queue decouples input from the sequencer, so the sender keeps going
// while results wait until it fills. Each slot visit is a table read, then an update:
// slot actions visit one slot, alloc and finds scan slots until a hit, ticks visit all.
// Reset empties the table, sets the board sequence to 1, zeroes the counters and
// loads the register defaults; no clearing pass is needed.
// A stalled result holds on the outputs; processing of the next transaction waits
// until every result of the current one has entered the output register.
module transaction_table_retry_timer import ttrt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  action,
	input  logic [2:0]  slot,
	input  logic [15:0] host_sn,
	input  logic [15:0] board_sn,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [2:0]  slot_out,
	output logic [15:0] board_seq_out,
	output logic [15:0] host_seq_out,
	output logic [1:0]  event_res,
	output logic [1:0]  retry_used,
	output logic [3:0]  pending_total,
	output logic [31:0] timeout_total,
	output logic [31:0] retry_total,
	output logic        last
);

	cfg_t   cfg_q;
	logic   q_valid, q_pop;
	item_t  q_item;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.host_to     <= 16'd250;
			cfg_q.ack_to      <= 16'd40;
			cfg_q.max_retries <= 2'd2;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_HOST_TO: cfg_q.host_to     <= pwdata[15:0];
				REG_ACK_TO:  cfg_q.ack_to      <= pwdata[15:0];
				REG_RETRIES: cfg_q.max_retries <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_HOST_TO: prdata = {16'd0, cfg_q.host_to};
			REG_ACK_TO:  prdata = {16'd0, cfg_q.ack_to};
			REG_RETRIES: prdata = {30'd0, cfg_q.max_retries};
			default:     prdata = '0;
		endcase
	end

	ttrt_front #(.SLOTS(SLOTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.slot      (slot),
		.host_sn   (host_sn),
		.board_sn  (board_sn),
		.now_ms    (now_ms),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	ttrt_back #(.SLOTS(SLOTS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ok            (ok),
		.slot_out      (slot_out),
		.board_seq_out (board_seq_out),
		.host_seq_out  (host_seq_out),
		.event_res     (event_res),
		.retry_used    (retry_used),
		.pending_total (pending_total),
		.timeout_total (timeout_total),
		.retry_total   (retry_total),
		.last          (last)
	);

endmodule
